FILE: rtl/core/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package swm_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_WINDOW = 64;

	localparam int VAL_W = 30;
	localparam int POS_W = 10;
	localparam int SUM_W = 50;
	localparam int DIM_W = 11;
	localparam int WIN_W = 7;
	localparam int CFG_IDX_W = 2;

	localparam int PTR_W = $clog2(MAX_WINDOW);
	localparam int CNT_W = PTR_W + 1;
	localparam int COLS_W = $clog2(MAX_WIDTH);
	localparam int COL_AW = COLS_W + PTR_W;
	localparam int COL_DEPTH = MAX_WIDTH * MAX_WINDOW;
	localparam int ENT_W = VAL_W + POS_W;
	localparam int HT_W = PTR_W + CNT_W;

	localparam int IN_TDATA_W = ((VAL_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = VAL_W + 2 * POS_W + SUM_W;
	localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMG_WIDTH  = 2'd0,
		REG_IMG_HEIGHT = 2'd1,
		REG_WIN_ROWS   = 2'd2,
		REG_WIN_COLS   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [VAL_W-1:0]  value;
		logic [POS_W-1:0]  col;
		logic [POS_W-1:0]  row;
		logic [WIN_W-1:0]  wc;
		logic [WIN_W-1:0]  wr;
		logic              row_reset;
		logic              col_push;
		logic [COLS_W-1:0] c0;
		logic              col_reset;
		logic              emit;
		logic [POS_W-1:0]  out_row;
		logic              frame_end;
	} cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/sliding_window_min_2d_core.sv
// An accepted item enters a two-entry command FIFO; the back end takes it when idle, expires
// old entries at the row queue head, drops larger ones at its tail, pushes the item, reads the
// front, and when a column window is complete does the same in that column's queue. A window's
// result is registered and held until taken. The back end handles one item at a time, set by
// the single read port of the queue memories; amortized pops stay below two per item.
// Reset: asynchronous, active low; a clearing pass then empties all column queues,
// and no item is accepted until it ends. Configuration returns to its reset values.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_min_2d_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [swm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [swm_pkg::DIM_W-1:0]         cfg_data,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [swm_pkg::IN_TDATA_W-1:0]    s_tdata,  // pixel_value
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [swm_pkg::OUT_TDATA_W-1:0]        m_tdata,  // window_min, window_row,
	                                                         // window_col, min_sum
	output logic                                   m_tlast
);
	import swm_pkg::*;

	cmd_t             front_cmd, fifo_cmd;
	logic             accept, fifo_full, fifo_valid, cmd_pop, clearing;
	logic [VAL_W-1:0] out_min;
	logic [POS_W-1:0] out_row, out_col;
	logic [SUM_W-1:0] out_sum;

	assign s_tready = !fifo_full && !clearing;
	assign accept   = s_tvalid && s_tready;
	assign m_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_sum, out_col, out_row, out_min};

	swm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_value (s_tdata[VAL_W-1:0]),
		.accept      (accept),
		.cmd         (front_cmd)
	);

	swm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.din    (front_cmd),
		.full   (fifo_full),
		.pop    (cmd_pop),
		.dout   (fifo_cmd),
		.valid  (fifo_valid)
	);

	swm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (fifo_valid),
		.cmd       (fifo_cmd),
		.cmd_pop   (cmd_pop),
		.clearing  (clearing),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_min   (out_min),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_sum   (out_sum),
		.out_last  (m_tlast)
	);

endmodule
`default_nettype wire

FILE: rtl/core/swm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module swm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/core/swm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module swm_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [swm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [swm_pkg::DIM_W-1:0]       cfg_data,
	input  wire logic [swm_pkg::VAL_W-1:0]       pixel_value,
	input  wire logic                            accept,
	output swm_pkg::cmd_t                        cmd
);
	import swm_pkg::*;

	logic [DIM_W-1:0] img_width_q, img_height_q;
	logic [WIN_W-1:0] win_rows_q, win_cols_q;
	logic [POS_W-1:0] cur_row_q, cur_col_q;
	logic [DIM_W-1:0] w_eff, h_eff, col_p1, row_p1;
	logic [WIN_W-1:0] wc_clamp, wr_clamp, wc_eff, wr_eff;
	logic             row_end, frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q  <= DIM_W'(MAX_WIDTH);
			img_height_q <= DIM_W'(MAX_HEIGHT);
			win_rows_q   <= WIN_W'(1);
			win_cols_q   <= WIN_W'(1);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IMG_WIDTH:  img_width_q <= cfg_data;
				REG_IMG_HEIGHT: img_height_q <= cfg_data;
				REG_WIN_ROWS:   win_rows_q <= cfg_data[WIN_W-1:0];
				REG_WIN_COLS:   win_cols_q <= cfg_data[WIN_W-1:0];
			endcase
		end
	end

	always_comb begin
		w_eff = (img_width_q == '0) ? DIM_W'(1) :
			((img_width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : img_width_q);
		h_eff = (img_height_q == '0) ? DIM_W'(1) :
			((img_height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : img_height_q);
		wc_clamp = (win_cols_q == '0) ? WIN_W'(1) :
			((win_cols_q > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : win_cols_q);
		wr_clamp = (win_rows_q == '0) ? WIN_W'(1) :
			((win_rows_q > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : win_rows_q);
		wc_eff = (DIM_W'(wc_clamp) > w_eff) ? w_eff[WIN_W-1:0] : wc_clamp;
		wr_eff = (DIM_W'(wr_clamp) > h_eff) ? h_eff[WIN_W-1:0] : wr_clamp;
		col_p1 = DIM_W'(cur_col_q) + DIM_W'(1);
		row_p1 = DIM_W'(cur_row_q) + DIM_W'(1);
		row_end = col_p1 >= w_eff;
		frame_end = row_end && (row_p1 >= h_eff);

		cmd.value     = pixel_value;
		cmd.col       = cur_col_q;
		cmd.row       = cur_row_q;
		cmd.wc        = wc_eff;
		cmd.wr        = wr_eff;
		cmd.row_reset = cur_col_q == '0;
		cmd.col_push  = col_p1 >= DIM_W'(wc_eff);
		cmd.c0        = COLS_W'(col_p1 - DIM_W'(wc_eff));
		cmd.col_reset = cur_row_q == '0;
		cmd.emit      = row_p1 >= DIM_W'(wr_eff);
		cmd.out_row   = POS_W'(row_p1 - DIM_W'(wr_eff));
		cmd.frame_end = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
		end else if (accept) begin
			priority if (frame_end) begin
				cur_row_q <= '0;
				cur_col_q <= '0;
			end else if (row_end) begin
				cur_col_q <= '0;
				cur_row_q <= cur_row_q + POS_W'(1);
			end else begin
				cur_col_q <= cur_col_q + POS_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/swm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module swm_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  swm_pkg::cmd_t      din,
	output logic               full,
	input  wire logic          pop,
	output swm_pkg::cmd_t      dout,
	output logic               valid
);
	import swm_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/swm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module swm_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cmd_valid,
	input  swm_pkg::cmd_t                   cmd,
	output logic                            cmd_pop,
	output logic                            clearing,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [swm_pkg::VAL_W-1:0]       out_min,
	output logic [swm_pkg::POS_W-1:0]       out_row,
	output logic [swm_pkg::POS_W-1:0]       out_col,
	output logic [swm_pkg::SUM_W-1:0]       out_sum,
	output logic                            out_last
);
	import swm_pkg::*;

	typedef enum logic [9:0] {
		ST_CLEAR    = 10'b0000000001,
		ST_IDLE     = 10'b0000000010,
		ST_EXP_RD   = 10'b0000000100,
		ST_EXP_CHK  = 10'b0000001000,
		ST_TAIL_RD  = 10'b0000010000,
		ST_TAIL_CHK = 10'b0000100000,
		ST_PUSH     = 10'b0001000000,
		ST_FRONT    = 10'b0010000000,
		ST_COL_LD   = 10'b0100000000,
		ST_OUT      = 10'b1000000000
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [PTR_W-1:0]  rhead_q, qhead_q;
	logic [CNT_W-1:0]  rcnt_q, qcnt_q;
	logic [VAL_W-1:0]  qv_q;
	logic [POS_W-1:0]  qidx_q;
	logic [WIN_W-1:0]  qwin_q;
	logic              phase_q;
	logic              bypass_q;
	logic [SUM_W-1:0]  sum_q;
	logic [COLS_W-1:0] clr_q;

	logic [PTR_W-1:0]  rd_ptr, push_head, push_ptr;
	logic [CNT_W-1:0]  push_cnt;
	logic              full;
	logic [ENT_W-1:0]  row_rdata, col_rdata, rdata;
	logic [VAL_W-1:0]  dval, front_val;
	logic [POS_W-1:0]  didx;
	logic              expired, out_load;
	logic [SUM_W-1:0]  sum_next;
	logic [HT_W-1:0]   ht_rdata, ht_wdata;
	logic [COLS_W-1:0] ht_waddr;
	logic              ht_we, row_we, col_we;

	always_comb begin
		full      = qcnt_q == CNT_W'(MAX_WINDOW);
		push_head = full ? qhead_q + PTR_W'(1) : qhead_q;
		push_cnt  = full ? qcnt_q - CNT_W'(1) : qcnt_q;
		push_ptr  = push_head + push_cnt[PTR_W-1:0];
		unique case (state_q)
			ST_TAIL_RD: rd_ptr = qhead_q + qcnt_q[PTR_W-1:0] - PTR_W'(1);
			ST_PUSH:    rd_ptr = push_head;
			default:    rd_ptr = qhead_q;
		endcase
		rdata     = phase_q ? col_rdata : row_rdata;
		dval      = rdata[ENT_W-1:POS_W];
		didx      = rdata[POS_W-1:0];
		expired   = ({1'b0, didx} + (POS_W + 1)'(qwin_q)) <= {1'b0, qidx_q};
		front_val = bypass_q ? qv_q : dval;
		row_we    = (state_q == ST_PUSH) && !phase_q;
		col_we    = (state_q == ST_PUSH) && phase_q;
		ht_we     = (state_q == ST_CLEAR) || ((state_q == ST_FRONT) && phase_q);
		ht_waddr  = (state_q == ST_CLEAR) ? clr_q : cmd_q.c0;
		ht_wdata  = (state_q == ST_CLEAR) ? '0 : {qhead_q, qcnt_q};
		out_load  = (state_q == ST_OUT) && (!out_valid || out_ready);
		sum_next  = sum_q + SUM_W'(qv_q);
		cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
		clearing  = state_q == ST_CLEAR;
	end

	swm_ram #(.WIDTH(ENT_W), .DEPTH(MAX_WINDOW)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (push_ptr),
		.wdata ({qv_q, qidx_q}),
		.raddr (rd_ptr),
		.rdata (row_rdata)
	);

	swm_ram #(.WIDTH(ENT_W), .DEPTH(COL_DEPTH)) u_col_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr ({cmd_q.c0, push_ptr}),
		.wdata ({qv_q, qidx_q}),
		.raddr ({cmd_q.c0, rd_ptr}),
		.rdata (col_rdata)
	);

	swm_ram #(.WIDTH(HT_W), .DEPTH(MAX_WIDTH)) u_ht_ram (
		.clk   (clk),
		.we    (ht_we),
		.waddr (ht_waddr),
		.wdata (ht_wdata),
		.raddr (cmd_q.c0),
		.rdata (ht_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (out_load) begin
			out_min  <= qv_q;
			out_row  <= cmd_q.out_row;
			out_col  <= POS_W'(cmd_q.c0);
			out_sum  <= sum_next;
			out_last <= cmd_q.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			rhead_q   <= '0;
			rcnt_q    <= '0;
			qhead_q   <= '0;
			qcnt_q    <= '0;
			qv_q      <= '0;
			qidx_q    <= '0;
			qwin_q    <= '0;
			phase_q   <= 1'b0;
			bypass_q  <= 1'b0;
			sum_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + COLS_W'(1);
					if (clr_q == COLS_W'(MAX_WIDTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						qhead_q <= cmd.row_reset ? '0 : rhead_q;
						qcnt_q  <= cmd.row_reset ? '0 : rcnt_q;
						qv_q    <= cmd.value;
						qidx_q  <= cmd.col;
						qwin_q  <= cmd.wc;
						phase_q <= 1'b0;
						state_q <= ST_EXP_RD;
					end
				end
				ST_EXP_RD: begin
					state_q <= (qcnt_q == '0) ? ST_TAIL_RD : ST_EXP_CHK;
				end
				ST_EXP_CHK: begin
					if (expired) begin
						qhead_q <= qhead_q + PTR_W'(1);
						qcnt_q  <= qcnt_q - CNT_W'(1);
						state_q <= ST_EXP_RD;
					end else begin
						state_q <= ST_TAIL_RD;
					end
				end
				ST_TAIL_RD: begin
					state_q <= (qcnt_q == '0) ? ST_PUSH : ST_TAIL_CHK;
				end
				ST_TAIL_CHK: begin
					if (dval > qv_q) begin
						qcnt_q  <= qcnt_q - CNT_W'(1);
						state_q <= ST_TAIL_RD;
					end else begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					qhead_q  <= push_head;
					qcnt_q   <= push_cnt + CNT_W'(1);
					bypass_q <= push_cnt == '0;
					state_q  <= ST_FRONT;
				end
				ST_FRONT: begin
					priority if (!phase_q) begin
						rhead_q <= qhead_q;
						rcnt_q  <= qcnt_q;
						if (cmd_q.col_push) begin
							qv_q    <= front_val;
							state_q <= ST_COL_LD;
						end else begin
							if (cmd_q.frame_end) begin
								sum_q <= '0;
							end
							state_q <= ST_IDLE;
						end
					end else if (cmd_q.emit) begin
						qv_q    <= front_val;
						state_q <= ST_OUT;
					end else begin
						if (cmd_q.frame_end) begin
							sum_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_COL_LD: begin
					qhead_q <= cmd_q.col_reset ? '0 : ht_rdata[HT_W-1:CNT_W];
					qcnt_q  <= cmd_q.col_reset ? '0 : ht_rdata[CNT_W-1:0];
					qidx_q  <= cmd_q.row;
					qwin_q  <= cmd_q.wr;
					phase_q <= 1'b1;
					state_q <= ST_EXP_RD;
				end
				ST_OUT: begin
					if (out_load) begin
						sum_q   <= cmd_q.frame_end ? '0 : sum_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_qcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= CNT_W'(MAX_WINDOW))
		else $error("queue count above window capacity");
	a_rcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= CNT_W'(MAX_WINDOW))
		else $error("row queue count above window capacity");
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !cmd_pop)
		else $error("command taken during clearing pass");
	a_out_loads: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid)
		else $error("result not presented after load");
`endif

endmodule
`default_nettype wire
